/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the spanning tree bridge.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent holds, consequent holds in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/stb_pkg.sv */
`timescale 1ns / 1ps
// Package for the spanning tree bridge: word types, request and register codes,
// and sizing constants. Depends on nothing.
package stb_pkg;

    // Sizing of the bridge.
    localparam int NUM_PORTS  = 8;
    localparam int ID_BITS    = 8;
    localparam int PORT_LIMIT = (NUM_PORTS < 8) ? NUM_PORTS : 8;
    localparam logic [3:0] LIVE_CAP = 4'(PORT_LIMIT);
    localparam logic [7:0] ID_MASK  = 8'((1 << ID_BITS) - 1);

    // Request codes.
    localparam logic [1:0] REQ_MSG   = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OWN_ID     = 1'b0;
    localparam logic CFG_PORT_COUNT = 1'b1;

    // One request word.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] in_root;
        logic [7:0] in_dist;
        logic [7:0] in_sender;
        logic [2:0] in_port;
    } req_word_t;

    // One result word.
    typedef struct packed {
        logic       send_valid;
        logic [2:0] send_port;
        logic [7:0] msg_root;
        logic [7:0] msg_dist;
        logic [7:0] msg_sender;
        logic       changed;
        logic [7:0] blocked_ports;
        logic       last;
    } rsp_word_t;

endpackage

/* src/spanning_tree_bridge_update_top.sv */
`timescale 1ns / 1ps
// Top level of the spanning tree bridge: state update, announcement job and
// result register. Depends on stb_pkg and assert_macros.svh.
//
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_word (stb_pkg::req_word_t)
//  rsp       out        rsp_valid/rsp_stall  rsp_word (stb_pkg::rsp_word_t)
//  cfg       in         cfg_we               cfg_index, cfg_data
//
// A request word updates the bridge state in the cycle it is accepted; its first
// result word goes through the announcement job register to the result register.
// Results leave one per cycle while rsp is not stalled, so a request causing n
// results occupies the announcement job register until the last has left; the next
// request is taken in the cycle the last result moves into the result register.
// Reset makes the bridge root with own id 0 and eight ports; no clearing pass.
// A stall on rsp holds the result register and, while a job is pending, req.
`include "assert_macros.svh"

module spanning_tree_bridge_update_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  stb_pkg::req_word_t req_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output stb_pkg::rsp_word_t rsp_word,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    // Configuration registers.
    logic [7:0] own_id_reg;
    logic [3:0] port_count_reg;

    // Bridge state.
    logic [7:0] best_root_reg, best_root_next;
    logic [7:0] root_dist_reg, root_dist_next;
    logic [7:0] parent_id_reg, parent_id_next;
    logic [2:0] root_port_reg, root_port_next;
    logic [7:0] blocked_mask_reg, blocked_mask_next;
    logic       is_root_reg, is_root_next;

    // Announcement job: ports still to announce and the fields they share.
    logic       job_valid_reg;
    logic [7:0] job_mask_reg;
    stb_pkg::rsp_word_t job_word_reg;

    // Result register.
    logic               out_valid_reg;
    stb_pkg::rsp_word_t out_word_reg;

    logic       accept;
    logic       emit;
    logic       chg;
    logic [7:0] skip;
    logic [7:0] me;
    logic [7:0] snd;
    logic [7:0] root_in;
    logic [7:0] nd;
    logic [7:0] pbit;
    logic [7:0] rport_bit;
    logic [3:0] live;
    logic [7:0] live_mask;
    logic [7:0] send_mask;
    logic [2:0] pick;
    logic [7:0] rest_mask;
    logic       emit_last;
    stb_pkg::rsp_word_t emit_word;

    // Number of live ports and their mask.
    always_comb
    begin
        live = (port_count_reg > stb_pkg::LIVE_CAP) ? stb_pkg::LIVE_CAP : port_count_reg;
        for (int k = 0; k < 8; k++)
        begin
            live_mask[k] = (4'(k) < live);
        end
    end

    // State update for the request word at the input.
    always_comb
    begin
        me      = own_id_reg & stb_pkg::ID_MASK;
        root_in = req_word.in_root & stb_pkg::ID_MASK;
        snd     = req_word.in_sender & stb_pkg::ID_MASK;
        nd      = (req_word.in_dist == 8'hFF) ? 8'hFF : req_word.in_dist + 8'd1;
        pbit    = 8'd1 << req_word.in_port;
        rport_bit = 8'd1 << root_port_reg;

        best_root_next    = best_root_reg;
        root_dist_next    = root_dist_reg;
        parent_id_next    = parent_id_reg;
        root_port_next    = root_port_reg;
        blocked_mask_next = blocked_mask_reg;
        is_root_next      = is_root_reg;
        chg  = 1'b0;
        skip = 8'hFF;

        case (req_word.req_type)
            stb_pkg::REQ_START:
            begin
                chg = (best_root_reg != me) || (root_dist_reg != 8'd0) ||
                      (parent_id_reg != me) || (root_port_reg != 3'd0);
                best_root_next    = me;
                root_dist_next    = 8'd0;
                parent_id_next    = me;
                root_port_next    = 3'd0;
                blocked_mask_next = 8'd0;
                is_root_next      = 1'b1;
                skip = 8'd0;
            end
            stb_pkg::REQ_TICK:
            begin
                skip = is_root_reg ? 8'd0 : 8'hFF;
            end
            stb_pkg::REQ_MSG:
            begin
                if ({1'b0, req_word.in_port} < live)
                begin
                    if (root_in < best_root_reg)
                    begin
                        best_root_next    = root_in;
                        root_dist_next    = nd;
                        parent_id_next    = snd;
                        root_port_next    = req_word.in_port;
                        blocked_mask_next = pbit;
                        is_root_next      = 1'b0;
                        chg = 1'b1;
                    end
                    else if (root_in == best_root_reg)
                    begin
                        if (nd < root_dist_reg)
                        begin
                            root_dist_next    = nd;
                            root_port_next    = req_word.in_port;
                            is_root_next      = 1'b0;
                            blocked_mask_next = pbit;
                            parent_id_next    = snd;
                            chg = 1'b1;
                        end
                        else if (nd == root_dist_reg && snd < parent_id_reg)
                        begin
                            blocked_mask_next = blocked_mask_reg | rport_bit;
                            root_port_next    = req_word.in_port;
                            is_root_next      = 1'b0;
                            parent_id_next    = snd;
                            chg = 1'b1;
                        end
                        else if (nd == root_dist_reg && snd > parent_id_reg)
                        begin
                            blocked_mask_next = blocked_mask_reg | pbit;
                        end
                        else if (nd == root_dist_reg)
                        begin
                            // Same parent: the lower port index becomes the root port.
                            if (req_word.in_port < root_port_reg)
                            begin
                                blocked_mask_next = blocked_mask_reg | rport_bit;
                                root_port_next    = req_word.in_port;
                                chg = 1'b1;
                            end
                            else
                            begin
                                blocked_mask_next = blocked_mask_reg | pbit;
                            end
                        end
                        else if (req_word.in_dist == root_dist_reg && me > snd)
                        begin
                            blocked_mask_next = blocked_mask_reg | pbit;
                        end
                    end
                    skip = blocked_mask_next;
                end
            end
            default:
            begin
                skip = 8'hFF;
            end
        endcase

        send_mask = live_mask & ~skip;
    end

    // Next result from the job: lowest port still pending.
    always_comb
    begin
        pick = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (job_mask_reg[k])
            begin
                pick = 3'(k);
            end
        end
        rest_mask = job_mask_reg & ~(8'd1 << pick);
        emit_last = (rest_mask == 8'd0);

        emit_word            = job_word_reg;
        emit_word.send_valid = (job_mask_reg != 8'd0);
        emit_word.send_port  = pick;
        emit_word.last       = emit_last;
    end

    // Handshakes.
    assign emit      = job_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = job_valid_reg && !(emit && emit_last);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    // Configuration, state, job and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg       <= 8'd0;
            port_count_reg   <= 4'd8;
            best_root_reg    <= 8'd0;
            root_dist_reg    <= 8'd0;
            parent_id_reg    <= 8'd0;
            root_port_reg    <= 3'd0;
            blocked_mask_reg <= 8'd0;
            is_root_reg      <= 1'b1;
            job_valid_reg    <= 1'b0;
            job_mask_reg     <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == stb_pkg::CFG_OWN_ID)
                begin
                    own_id_reg <= cfg_data;
                end
                else
                begin
                    port_count_reg <= cfg_data[3:0];
                end
            end

            if (accept)
            begin
                best_root_reg    <= best_root_next;
                root_dist_reg    <= root_dist_next;
                parent_id_reg    <= parent_id_next;
                root_port_reg    <= root_port_next;
                blocked_mask_reg <= blocked_mask_next;
                is_root_reg      <= is_root_next;
            end

            // A new request replaces the job in the cycle its last word leaves.
            if (accept)
            begin
                job_valid_reg <= 1'b1;
                job_mask_reg  <= send_mask;
            end
            else if (emit)
            begin
                job_valid_reg <= !emit_last;
                job_mask_reg  <= rest_mask;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_word_reg.send_valid    <= 1'b0;
            job_word_reg.send_port     <= 3'd0;
            job_word_reg.msg_root      <= best_root_next;
            job_word_reg.msg_dist      <= root_dist_next;
            job_word_reg.msg_sender    <= own_id_reg & stb_pkg::ID_MASK;
            job_word_reg.changed       <= chg;
            job_word_reg.blocked_ports <= blocked_mask_next & ~(8'd1 << root_port_next);
            job_word_reg.last          <= 1'b0;
        end
        if (emit)
        begin
            out_word_reg <= emit_word;
        end
    end

    // Checks on the announcement sequencing.
    `ASSERT_NEXT(a_burst_continues, rsp_valid && !rsp_stall && !rsp_word.last, rsp_valid,
        "result burst broken before its last word")
    `ASSERT_SAME(a_silent_is_last, rsp_valid && !rsp_word.send_valid,
        rsp_word.last && (rsp_word.send_port == 3'd0), "silent result not single")
    `ASSERT_NEXT(a_accept_starts_job, accept, job_valid_reg,
        "accepted request started no job")

endmodule

/* verif/spanning_tree_bridge_update_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for spanning_tree_bridge_update_top: feeds request words
// from a queue, tracks the bridge's belief and checks every announcement word.
// Depends on stb_pkg and the RTL of the bridge.
module spanning_tree_bridge_update_top_tb;

    localparam logic [1:0] REQ_IGNORED = 2'd3;
    localparam int STALL_PCT      = 18;
    localparam int HOLD_CYCLES    = 120;
    localparam int HOLD_AT_WORD   = 150;
    localparam int REPORT_MAX     = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    stb_pkg::req_word_t req_word  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    stb_pkg::rsp_word_t rsp_word;
    logic               cfg_we    = 1'b0;
    logic               cfg_index = 1'b0;
    logic [7:0]         cfg_data  = '0;

    // Registers and spanning tree belief as the testbench tracks them.
    logic [7:0] my_id        = 8'd0;
    logic [3:0] ports_cfg    = 4'd8;
    logic [7:0] best_root    = 8'd0;
    logic [7:0] root_dist    = 8'd0;
    logic [7:0] parent       = 8'd0;
    logic [2:0] up_port      = 3'd0;
    logic [7:0] block_mask   = 8'd0;
    logic       believe_root = 1'b1;

    stb_pkg::rsp_word_t expected_words[$];
    stb_pkg::req_word_t pending_words[$];
    logic [7:0] root_pool[3];
    logic [7:0] sender_pool[4];

    int  queued = 0;
    int  accepted = 0;
    int  words_seen = 0;
    int  mismatches = 0;
    int  n_start = 0;
    int  n_tick = 0;
    int  n_msg = 0;
    int  n_other = 0;
    int  settings_run = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  steady = 1'b0;

    spanning_tree_bridge_update_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Ports actually in use: the register value capped by the build size.
    function automatic int live_ports();
        if (ports_cfg > stb_pkg::LIVE_CAP)
            return int'(stb_pkg::LIVE_CAP);
        return int'(ports_cfg);
    endfunction

    function automatic void become_root();
        best_root    = my_id & stb_pkg::ID_MASK;
        root_dist    = 8'd0;
        parent       = my_id & stb_pkg::ID_MASK;
        up_port      = 3'd0;
        block_mask   = 8'd0;
        believe_root = 1'b1;
    endfunction

    // Expected words for one request: an announcement on every live port not
    // skipped, or a single empty word when there is nothing to send.
    function automatic void announce(input logic [7:0] skip, input logic chg);
        stb_pkg::rsp_word_t words[8];
        stb_pkg::rsp_word_t w;
        int                 n;
        n = 0;
        w.send_valid    = 1'b1;
        w.send_port     = 3'd0;
        w.msg_root      = best_root;
        w.msg_dist      = root_dist;
        w.msg_sender    = my_id & stb_pkg::ID_MASK;
        w.changed       = chg;
        w.blocked_ports = block_mask & ~(8'd1 << up_port);
        w.last          = 1'b0;
        for (int k = 0; k < live_ports(); k++)
        begin
            if (!skip[k])
            begin
                w.send_port = 3'(k);
                words[n] = w;
                n++;
            end
        end
        if (n == 0)
        begin
            w.send_valid = 1'b0;
            w.send_port  = 3'd0;
            words[0] = w;
            n = 1;
        end
        words[n - 1].last = 1'b1;
        for (int k = 0; k < n; k++)
            expected_words.insert(expected_words.size(), words[k]);
    endfunction

    // Applies one accepted request to the tracked belief and queues its words.
    function automatic void predict_request(input stb_pkg::req_word_t r);
        logic [7:0] me;
        logic [7:0] root;
        logic [7:0] snd;
        logic [7:0] nd;
        logic [7:0] pbit;
        logic       chg;
        me   = my_id & stb_pkg::ID_MASK;
        root = r.in_root & stb_pkg::ID_MASK;
        snd  = r.in_sender & stb_pkg::ID_MASK;
        nd   = (r.in_dist == 8'hFF) ? 8'hFF : r.in_dist + 8'd1;
        pbit = 8'd1 << r.in_port;
        chg  = 1'b0;
        case (r.req_type)
            stb_pkg::REQ_START:
            begin
                n_start++;
                chg = (best_root != me) || (root_dist != 8'd0) || (parent != me) ||
                      (up_port != 3'd0);
                become_root();
                announce(8'h00, chg);
            end
            stb_pkg::REQ_TICK:
            begin
                n_tick++;
                announce(believe_root ? 8'h00 : 8'hFF, 1'b0);
            end
            stb_pkg::REQ_MSG:
            begin
                n_msg++;
                if (int'(r.in_port) >= live_ports())
                    announce(8'hFF, 1'b0);
                else
                begin
                    if (root < best_root)
                    begin
                        best_root    = root;
                        root_dist    = nd;
                        parent       = snd;
                        up_port      = r.in_port;
                        block_mask   = pbit;
                        believe_root = 1'b0;
                        chg          = 1'b1;
                    end
                    else if (root == best_root)
                    begin
                        if (nd < root_dist)
                        begin
                            root_dist    = nd;
                            up_port      = r.in_port;
                            believe_root = 1'b0;
                            block_mask   = pbit;
                            parent       = snd;
                            chg          = 1'b1;
                        end
                        else if (nd == root_dist && snd < parent)
                        begin
                            block_mask   = block_mask | (8'd1 << up_port);
                            up_port      = r.in_port;
                            believe_root = 1'b0;
                            parent       = snd;
                            chg          = 1'b1;
                        end
                        else if (nd == root_dist && snd > parent)
                            block_mask = block_mask | pbit;
                        else if (nd == root_dist)
                        begin
                            // Same parent heard again: prefer the lower port.
                            if (r.in_port < up_port)
                            begin
                                block_mask = block_mask | (8'd1 << up_port);
                                up_port    = r.in_port;
                                chg        = 1'b1;
                            end
                            else
                                block_mask = block_mask | pbit;
                        end
                        else if (r.in_dist == root_dist && me > snd)
                            block_mask = block_mask | pbit;
                    end
                    announce(block_mask, chg);
                end
            end
            default:
            begin
                n_other++;
                announce(8'hFF, 1'b0);
            end
        endcase
    endfunction

    // Compares one result word with the oldest expectation.
    function automatic void check_word(input stb_pkg::rsp_word_t got);
        stb_pkg::rsp_word_t want;
        bit                 bad;
        words_seen++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("Unexpected result word at %0t: %h", $realtime, got);
            return;
        end
        want = expected_words.pop_front();
        bad = (got.send_valid !== want.send_valid) || (got.send_port !== want.send_port) ||
              (got.msg_root !== want.msg_root) || (got.msg_dist !== want.msg_dist) ||
              (got.msg_sender !== want.msg_sender) || (got.changed !== want.changed) ||
              (got.blocked_ports !== want.blocked_ports) || (got.last !== want.last);
        if (bad)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("Result word %0d wrong at %0t (valid port root dist sender chg blk last)",
                         words_seen, $realtime);
                $display("  expected %b %0d %h %h %h %b %b %b", want.send_valid, want.send_port,
                         want.msg_root, want.msg_dist, want.msg_sender, want.changed,
                         want.blocked_ports, want.last);
                $display("  actual   %b %0d %h %h %h %b %b %b", got.send_valid, got.send_port,
                         got.msg_root, got.msg_dist, got.msg_sender, got.changed,
                         got.blocked_ports, got.last);
            end
        end
    endfunction

    // Request driver: takes words from the pending queue, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                predict_request(req_word);
                accepted++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() > 0 && (steady || $urandom_range(99) >= STALL_PCT))
                begin
                    req_valid <= 1'b1;
                    req_word  <= pending_words.pop_front();
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks accepted words and stalls at random, with one long
    // hold-off so that the bridge backs up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_word(rsp_word);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (!hold_done && words_seen >= HOLD_AT_WORD)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= !steady && ($urandom_range(99) < STALL_PCT);
        end
    end

    // Ends the run if no word moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("No word moved on either channel for %0d cycles.", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == stb_pkg::CFG_OWN_ID)
            my_id = value;
        else
            ports_cfg = value[3:0];
    endtask

    function automatic stb_pkg::req_word_t compose(input logic [1:0] kind,
                                                   input logic [7:0] root,
                                                   input logic [7:0] hops,
                                                   input logic [7:0] sender,
                                                   input logic [2:0] port);
        stb_pkg::req_word_t r;
        r.req_type  = kind;
        r.in_root   = root;
        r.in_dist   = hops;
        r.in_sender = sender;
        r.in_port   = port;
        return r;
    endfunction

    function automatic void push_request(input stb_pkg::req_word_t r);
        pending_words.insert(pending_words.size(), r);
        queued++;
    endfunction

    // Mostly messages drawn from small pools of roots and senders, so that
    // ties on root, distance and parent come up often; the rest is noise.
    function automatic stb_pkg::req_word_t random_request(input int ports);
        stb_pkg::req_word_t r;
        int                 pick;
        pick = $urandom_range(99);
        r.in_root   = root_pool[$urandom_range(2)];
        r.in_dist   = ($urandom_range(9) == 0) ? 8'(253 + $urandom_range(2))
                                               : 8'($urandom_range(3));
        r.in_sender = sender_pool[$urandom_range(3)];
        r.in_port   = (ports > 0 && $urandom_range(7) != 0) ? 3'($urandom_range(ports - 1))
                                                            : 3'($urandom_range(7));
        if (pick < 78)
            r.req_type = stb_pkg::REQ_MSG;
        else if (pick < 88)
            r.req_type = stb_pkg::REQ_TICK;
        else if (pick < 92)
            r.req_type = stb_pkg::REQ_START;
        else if (pick < 95)
            r.req_type = REQ_IGNORED;
        else
            r = 29'($urandom);
        return r;
    endfunction

    // Waits until every word has gone through, then a little longer.
    task automatic wait_quiet();
        while (accepted < queued || expected_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register setting: write both registers, restart the bridge, then a
    // run of random requests.
    task automatic run_phase(input logic [7:0] own, input logic [7:0] count_word,
                             input int items);
        int ports;
        int lo;
        write_reg(stb_pkg::CFG_OWN_ID, own);
        write_reg(stb_pkg::CFG_PORT_COUNT, count_word);
        ports = live_ports();
        lo = $urandom_range(int'(own));
        root_pool[0] = 8'(lo);
        root_pool[1] = 8'(lo + 1);
        root_pool[2] = own;
        for (int k = 0; k < 4; k++)
            sender_pool[k] = 8'($urandom_range(255));
        push_request(compose(stb_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 3'd0));
        for (int k = 0; k < items; k++)
            push_request(random_request(ports));
        settings_run++;
        wait_quiet();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: every request type, each tie-break and the extremes.
        write_reg(stb_pkg::CFG_OWN_ID, 8'h80);
        write_reg(stb_pkg::CFG_PORT_COUNT, 8'd8);
        settings_run++;
        push_request(compose(stb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0));
        push_request(compose(stb_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 3'd0));
        push_request(compose(stb_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 3'd0));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd3, 8'h41, 3'd2));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h50, 3'd5));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h30, 3'd6));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h60, 3'd1));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h30, 3'd3));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h30, 3'd3));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd1, 8'h30, 3'd7));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd2, 8'h10, 3'd4));
        push_request(compose(stb_pkg::REQ_MSG, 8'h40, 8'd2, 8'hFF, 3'd0));
        push_request(compose(stb_pkg::REQ_MSG, 8'h90, 8'd0, 8'h00, 3'd1));
        push_request(compose(stb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0));
        push_request(compose(REQ_IGNORED, 8'hFF, 8'hFF, 8'hFF, 3'd7));
        push_request(compose(stb_pkg::REQ_MSG, 8'h00, 8'hFF, 8'h00, 3'd0));
        push_request(compose(stb_pkg::REQ_MSG, 8'h00, 8'hFE, 8'h01, 3'd1));
        push_request(compose(stb_pkg::REQ_MSG, 8'hFF, 8'hFF, 8'hFF, 3'd7));
        push_request(compose(stb_pkg::REQ_START, 8'h00, 8'h00, 8'h00, 3'd0));
        push_request(compose(stb_pkg::REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0));
        wait_quiet();

        // Random part over several settings, the extremes among them.
        run_phase(8'h00, 8'd1, 40);
        steady = 1'b1;
        run_phase(8'hFF, 8'd8, 45);
        steady = 1'b0;
        run_phase(8'($urandom_range(255)), 8'd0, 15);
        run_phase(8'($urandom_range(255)), {4'($urandom_range(15)), 4'd15}, 45);
        repeat (5)
            run_phase(8'($urandom_range(255)),
                      {4'($urandom_range(15)), 4'($urandom_range(2, 7))}, 40);

        $display("Ran %0d requests (%0d start, %0d tick, %0d message, %0d other),",
                 accepted, n_start, n_tick, n_msg, n_other);
        $display("%0d words over %0d register settings, %0s long hold-off; %0d mismatches.",
                 words_seen, settings_run, hold_done ? "with a" : "no", mismatches);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
